>>> rtl/core/bpa_pkg.sv
// Shared types and codes for the buddy page allocator.
package bpa_pkg;

    typedef enum logic [3:0] {
        S_CLR,
        S_FREE,
        S_INS_BEG,
        S_INS_CHK,
        S_INS_CMP,
        S_INS_WR,
        S_IDLE,
        S_SCAN,
        S_TAKE,
        S_SPLIT,
        S_DONE
    } t_state;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef enum logic {
        STAT_DONE    = 1'b0,
        STAT_NO_FIT  = 1'b1
    } t_status;

endpackage

>>> rtl/core/buddy_page_allocator.sv
// Buddy page allocator: top level with the request sequencer and the order map.
// Allocate: scans the order map one page per cycle, stopping early when a block of the
//   first order searched turns up, then hands back each surplus block, merging buddies;
//   a free walks the order steps and inserts each block, merging buddies.
// Throughput: one transaction at a time; the map RAM port sets the pace.
// Reset (synchronous, active low): a clearing pass over all TOTAL_PAGES entries wipes the map,
//   then all pages are freed from page 0; o_in_ready stays low until that is done.
module buddy_page_allocator #(
    parameter int TOTAL_PAGES = 1024,
    parameter int MAX_ORDER   = 10,
    parameter int PAGE_SHIFT  = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [31:0] i_address,
    input  logic [22:0] i_size_bytes,
    input  logic [3:0]  i_min_order,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_alloc_address,
    output logic        o_status
);
    import bpa_pkg::*;

    // Widths
    localparam int PAW  = $clog2(TOTAL_PAGES);      // map address
    localparam int CNTW = $clog2(TOTAL_PAGES + 1);  // sweep counter, reaches TOTAL_PAGES
    localparam int VW   = $clog2(MAX_ORDER + 2);    // map entry: order + 1
    localparam int NW   = 24 - PAGE_SHIFT;          // page count of one request
    localparam int WPW  = 34 - PAGE_SHIFT;          // unbounded page numbers and sizes

    localparam logic [WPW-1:0] WONE   = WPW'(1);
    localparam logic [WPW-1:0] WTOTAL = WPW'(TOTAL_PAGES);
    localparam logic [VW-1:0]  VMAX   = VW'(MAX_ORDER);
    localparam logic [VW-1:0]  VONE   = VW'(1);

    // Ceiling log2 of a page count (count >= 1).
    function automatic logic [4:0] f_ceil_log2(input logic [NW-1:0] cnt);
        logic [NW-1:0] m;
        logic [4:0]    r;
        m = cnt - NW'(1);
        r = '0;
        for (int i = 0; i < NW; i++) begin
            if (m[i]) r = 5'(i + 1);
        end
        return r;
    endfunction

    t_state           r_state, n_state;
    logic [31:0]      r_base, n_base;
    logic             r_init, n_init;
    logic             r_ret_free, n_ret_free;   // insert returns to free loop, else split loop
    logic [WPW-1:0]   r_first, n_first;
    logic [WPW-1:0]   r_left, n_left;
    logic [VW-1:0]    r_ford, n_ford;
    logic [WPW-1:0]   r_ins_page, n_ins_page;
    logic [VW-1:0]    r_ins_ord, n_ins_ord;
    logic [NW-1:0]    r_need, n_need;
    logic [VW-1:0]    r_k, n_k;
    logic             r_found, n_found;
    logic [VW-1:0]    r_best_ord, n_best_ord;
    logic [PAW-1:0]   r_best_page, n_best_page;
    logic [CNTW-1:0]  r_cnt, n_cnt;
    logic             r_scan_vld, n_scan_vld;
    logic [PAW-1:0]   r_scan_page, n_scan_page;
    logic [WPW-1:0]   r_surp, n_surp;
    logic [WPW-1:0]   r_next, n_next;
    logic [VW-1:0]    r_sord, n_sord;
    logic [31:0]      r_res_addr, n_res_addr;
    logic             r_res_stat, n_res_stat;
    logic             r_out_valid, n_out_valid;
    logic [31:0]      r_out_addr, n_out_addr;
    logic             r_out_stat, n_out_stat;

    // map RAM port
    logic             mem_we;
    logic [PAW-1:0]   mem_waddr;
    logic [VW-1:0]    mem_wdata;
    logic [PAW-1:0]   mem_raddr;
    logic [VW-1:0]    mem_rdata;

    bpa_ram #(
        .WIDTH (VW),
        .DEPTH (TOTAL_PAGES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Request decode
    logic [23:0]    size_rnd;
    logic [NW-1:0]  need_raw;
    logic [NW-1:0]  need_a;
    logic [4:0]     need_ord;
    logic [WPW-1:0] free_first;
    logic [31:0]    rel_addr;

    assign size_rnd   = {1'b0, i_size_bytes} + 24'((32'd1 << PAGE_SHIFT) - 1);
    assign need_raw   = size_rnd[23:PAGE_SHIFT];
    assign need_a     = (need_raw == '0) ? NW'(1) : need_raw;
    assign need_ord   = f_ceil_log2(need_a);
    assign rel_addr   = i_address - r_base;
    assign free_first = WPW'(rel_addr >> PAGE_SHIFT);

    // Insert unit helpers
    logic [WPW-1:0] ins_sz;
    logic [WPW-1:0] ins_buddy;
    assign ins_sz    = WONE << r_ins_ord;
    assign ins_buddy = r_ins_page ^ ins_sz;

    // Scan compare on returning map data
    logic [VW-1:0] scan_ord;
    logic          scan_hit;
    assign scan_ord = mem_rdata - VONE;
    assign scan_hit = r_scan_vld && (mem_rdata != '0) && (scan_ord >= r_k)
                      && (!r_found || (scan_ord < r_best_ord));

    logic [WPW-1:0] left_dec;
    assign left_dec = r_left - (WONE << r_ford);

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_base      <= '0;
            r_init      <= 1'b1;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_scan_vld  <= 1'b0;
            r_found     <= 1'b0;
            r_ret_free  <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_init      <= n_init;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_scan_vld  <= n_scan_vld;
            r_found     <= n_found;
            r_ret_free  <= n_ret_free;
        end
        r_first     <= n_first;
        r_left      <= n_left;
        r_ford      <= n_ford;
        r_ins_page  <= n_ins_page;
        r_ins_ord   <= n_ins_ord;
        r_need      <= n_need;
        r_k         <= n_k;
        r_best_ord  <= n_best_ord;
        r_best_page <= n_best_page;
        r_scan_page <= n_scan_page;
        r_surp      <= n_surp;
        r_next      <= n_next;
        r_sord      <= n_sord;
        r_res_addr  <= n_res_addr;
        r_res_stat  <= n_res_stat;
        r_out_addr  <= n_out_addr;
        r_out_stat  <= n_out_stat;
    end

    always_comb begin
        n_state     = r_state;
        n_base      = i_cfg_we ? i_cfg_wdata : r_base;
        n_init      = r_init;
        n_ret_free  = r_ret_free;
        n_first     = r_first;
        n_left      = r_left;
        n_ford      = r_ford;
        n_ins_page  = r_ins_page;
        n_ins_ord   = r_ins_ord;
        n_need      = r_need;
        n_k         = r_k;
        n_found     = r_found;
        n_best_ord  = r_best_ord;
        n_best_page = r_best_page;
        n_cnt       = r_cnt;
        n_scan_vld  = 1'b0;
        n_scan_page = r_scan_page;
        n_surp      = r_surp;
        n_next      = r_next;
        n_sord      = r_sord;
        n_res_addr  = r_res_addr;
        n_res_stat  = r_res_stat;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_addr  = r_out_addr;
        n_out_stat  = r_out_stat;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_raddr   = '0;

        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt[PAW-1:0];
                n_cnt     = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(TOTAL_PAGES - 1)) begin
                    n_first = '0;
                    n_left  = WTOTAL;
                    n_ford  = '0;
                    n_init  = 1'b1;
                    n_state = S_FREE;
                end
            end

            // Free loop: peel power-of-two blocks off the end of the range.
            S_FREE: begin
                if (r_left == '0) begin
                    if (r_init) begin
                        n_init  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_res_addr = '0;
                        n_res_stat = STAT_DONE;
                        n_state    = S_DONE;
                    end
                end else begin
                    if (r_left[r_ford] || (r_ford == VMAX)) begin
                        n_left     = left_dec;
                        n_ins_page = r_first + left_dec;
                        n_ins_ord  = r_ford;
                        n_ret_free = 1'b1;
                        n_state    = S_INS_BEG;
                    end
                    if (r_ford < VMAX) n_ford = r_ford + VONE;
                end
            end

            // Insert unit: range check, then merge with free buddies.
            S_INS_BEG: begin
                if ((r_ins_page + ins_sz) > WTOTAL) begin
                    n_state = r_ret_free ? S_FREE : S_SPLIT;
                end else begin
                    n_state = S_INS_CHK;
                end
            end

            S_INS_CHK: begin
                mem_raddr = ins_buddy[PAW-1:0];
                if ((r_ins_ord < VMAX) && ((r_ins_page & (ins_sz - WONE)) == '0)
                    && (ins_buddy < WTOTAL)) begin
                    n_state = S_INS_CMP;
                end else begin
                    n_state = S_INS_WR;
                end
            end

            S_INS_CMP: begin
                if (mem_rdata == (r_ins_ord + VONE)) begin
                    mem_we     = 1'b1;
                    mem_waddr  = ins_buddy[PAW-1:0];
                    n_ins_page = r_ins_page & ~ins_sz;
                    n_ins_ord  = r_ins_ord + VONE;
                    n_state    = S_INS_CHK;
                end else begin
                    n_state = S_INS_WR;
                end
            end

            S_INS_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_ins_page[PAW-1:0];
                mem_wdata = r_ins_ord + VONE;
                n_state   = r_ret_free ? S_FREE : S_SPLIT;
            end

            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_action == ACT_FREE) begin
                        n_first = free_first;
                        n_left  = WPW'(need_raw);
                        n_ford  = '0;
                        n_state = S_FREE;
                    end else if ((need_ord > 5'(MAX_ORDER))
                                 || (i_min_order > 4'(MAX_ORDER))) begin
                        n_res_addr = '0;
                        n_res_stat = STAT_NO_FIT;
                        n_state    = S_DONE;
                    end else begin
                        n_need  = need_a;
                        n_k     = (VW'(i_min_order) > VW'(need_ord)) ?
                                  VW'(i_min_order) : VW'(need_ord);
                        n_found = 1'b0;
                        n_cnt   = '0;
                        n_state = S_SCAN;
                    end
                end
            end

            // One page per cycle; keep the lowest page of the smallest fitting order.
            S_SCAN: begin
                if (r_cnt != CNTW'(TOTAL_PAGES)) begin
                    mem_raddr   = r_cnt[PAW-1:0];
                    n_cnt       = r_cnt + CNTW'(1);
                    n_scan_vld  = 1'b1;
                    n_scan_page = r_cnt[PAW-1:0];
                end
                if (scan_hit) begin
                    n_found     = 1'b1;
                    n_best_ord  = scan_ord;
                    n_best_page = r_scan_page;
                end
                if ((scan_hit && (scan_ord == r_k))
                    || ((r_cnt == CNTW'(TOTAL_PAGES)) && !r_scan_vld)) begin
                    n_scan_vld = 1'b0;
                    n_state    = S_TAKE;
                end
            end

            S_TAKE: begin
                if (!r_found) begin
                    n_res_addr = '0;
                    n_res_stat = STAT_NO_FIT;
                    n_state    = S_DONE;
                end else begin
                    mem_we     = 1'b1;
                    mem_waddr  = r_best_page;
                    n_surp     = (WONE << r_best_ord) - WPW'(r_need);
                    n_next     = WPW'(r_best_page) + WPW'(r_need);
                    n_sord     = '0;
                    n_res_addr = r_base + 32'({r_best_page, {PAGE_SHIFT{1'b0}}});
                    n_res_stat = STAT_DONE;
                    n_state    = S_SPLIT;
                end
            end

            // Hand back surplus pages, smallest order first.
            S_SPLIT: begin
                if (r_surp == '0) begin
                    n_state = S_DONE;
                end else begin
                    if (r_surp[0]) begin
                        n_ins_page = r_next;
                        n_ins_ord  = r_sord;
                        n_next     = r_next + (WONE << r_sord);
                        n_ret_free = 1'b0;
                        n_state    = S_INS_BEG;
                    end
                    n_surp = r_surp >> 1;
                    n_sord = r_sord + VONE;
                end
            end

            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_addr  = r_res_addr;
                    n_out_stat  = r_res_stat;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_alloc_address = r_out_addr;
    assign o_status        = r_out_stat;

    // A transaction holds the block until its result is queued.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("accepted a second transaction while busy");

    // A failed allocate reports no address.
    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STAT_NO_FIT)) |-> (o_alloc_address == '0))
        else $error("failed allocate with nonzero address");

    // Blocks written to the map lie inside the managed range.
    a_ins_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_WR) |-> ((r_ins_page + ins_sz) <= WTOTAL))
        else $error("block inserted beyond managed range");

    // No new request while the reset sweep or initial free runs.
    a_init_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !o_in_ready)
        else $error("ready during initialization");

endmodule

>>> rtl/core/bpa_ram.sv
// Generic single write, single read RAM with registered read data.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> test/testbench.sv
// Self-checking testbench for the buddy page allocator.
`timescale 1ns / 100ps

module testbench;
    import bpa_pkg::*;

    localparam int TOTAL_PAGES  = 1024;
    localparam int MAX_ORDER    = 10;
    localparam int PAGE_SHIFT   = 12;
    localparam int PAGE_BYTES   = 1 << PAGE_SHIFT;
    // one allocate scans the whole map, plus splits and merges
    localparam int DRAIN_CYCLES = TOTAL_PAGES + 300;
    // length of the receiver's forced stretch with ready low
    localparam int HOLD_CYCLES  = 3000;
    localparam int WATCHDOG     = 40000;
    localparam int N_RANDOM     = 1920;

    typedef struct {
        logic [31:0] alloc_address;
        t_status     status;
    } t_grant;

    typedef struct {
        int unsigned page;
        int unsigned bytes;
    } t_region;

    // Scoreboard: keeps its own copy of the free-block map and the base address,
    // predicts each transaction's result and checks results in order.
    class alloc_scoreboard;
        logic [3:0]  start_order [TOTAL_PAGES];
        logic [31:0] base;
        t_grant      grant_q[$];
        int          errors;

        function new();
            errors = 0;
            reset_map();
        endfunction

        function void reset_map();
            base = '0;
            foreach (start_order[i]) start_order[i] = '0;
            release_pages(0, TOTAL_PAGES);
        endfunction

        // insert one block, merging with free buddies of the same order
        function void place_block(longint unsigned page, int unsigned order);
            longint unsigned blk, buddy;
            if (page + (64'd1 << order) > TOTAL_PAGES) return;
            while (order < MAX_ORDER) begin
                blk = 64'd1 << order;
                if ((page & (blk - 1)) != 0) break;
                buddy = page ^ blk;
                if (buddy >= TOTAL_PAGES || start_order[buddy] != 4'(order + 1)) break;
                start_order[buddy] = '0;
                page = page & ~blk;
                order++;
            end
            start_order[page] = 4'(order + 1);
        endfunction

        // split a page run into power-of-two blocks, taken from the end
        function void release_pages(longint unsigned first, int unsigned count);
            int unsigned left, order;
            left  = count;
            order = 0;
            while (left != 0) begin
                if (((left >> order) & 1) != 0 || order == MAX_ORDER) begin
                    left -= (1 << order);
                    place_block(first + left, order);
                end
                if (order < MAX_ORDER) order++;
            end
        endfunction

        function t_grant note_request(t_action act, logic [31:0] addr,
                                      logic [22:0] size, logic [3:0] min_ord);
            t_grant      g;
            int unsigned need, need_ord, surplus, nxt, o, k;
            logic [31:0] rel;
            bit          found;
            g.alloc_address = '0;
            g.status        = STAT_DONE;
            found           = 0;
            need = (32'(size) + PAGE_BYTES - 1) >> PAGE_SHIFT;
            if (act == ACT_FREE) begin
                rel = addr - base;
                release_pages(rel >> PAGE_SHIFT, need);
            end else begin
                if (need == 0) need = 1;
                need_ord = 0;
                while (need_ord <= MAX_ORDER && (1 << need_ord) < need) need_ord++;
                if (need_ord > MAX_ORDER || min_ord > MAX_ORDER) begin
                    g.status = STAT_NO_FIT;
                end else begin
                    k = (min_ord > need_ord) ? min_ord : need_ord;
                    for (; k <= MAX_ORDER && !found; k++) begin
                        for (int p = 0; p < TOTAL_PAGES && !found; p++) begin
                            if (start_order[p] == 4'(k + 1)) begin
                                found          = 1;
                                start_order[p] = '0;
                                surplus        = (1 << k) - need;
                                nxt            = p + need;
                                o              = 0;
                                // trailing surplus goes back smallest order first
                                while (surplus != 0) begin
                                    if (surplus & 1) begin
                                        place_block(nxt, o);
                                        nxt += (1 << o);
                                    end
                                    surplus >>= 1;
                                    o++;
                                end
                                g.alloc_address = base + (32'(p) << PAGE_SHIFT);
                            end
                        end
                    end
                    if (!found) g.status = STAT_NO_FIT;
                end
            end
            grant_q.push_back(g);
            return g;
        endfunction

        function void check_result(logic [31:0] addr, logic stat);
            t_grant g;
            if (grant_q.size() == 0) begin
                $error("result with nothing pending: alloc_address %h status %0d", addr, stat);
                errors++;
                return;
            end
            g = grant_q.pop_front();
            if (addr !== g.alloc_address) begin
                $error("alloc_address expected %h actual %h", g.alloc_address, addr);
                errors++;
            end
            if (stat !== g.status) begin
                $error("status expected %0d actual %0d", g.status, stat);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_action;
    logic [31:0] i_address;
    logic [22:0] i_size_bytes;
    logic [3:0]  i_min_order;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_alloc_address;
    logic        o_status;

    buddy_page_allocator #(
        .TOTAL_PAGES (TOTAL_PAGES),
        .MAX_ORDER   (MAX_ORDER),
        .PAGE_SHIFT  (PAGE_SHIFT)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_address       (i_address),
        .i_size_bytes    (i_size_bytes),
        .i_min_order     (i_min_order),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_alloc_address (o_alloc_address),
        .o_status        (o_status)
    );

    alloc_scoreboard sb = new();
    t_region         live_q[$];     // regions handed out and not yet returned
    bit              hold_out;      // asks the receiver for a long stall
    int              burst_left;
    int              quiet_cycles = 0;

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: ready follows a randomly picked mode (always, half, a quarter or a sixteenth of the time);
    // a hold request forces a long stretch with ready low.
    initial begin
        int mode, left;
        i_out_ready = 1'b0;
        mode        = 0;
        left        = 0;
        forever begin
            @(posedge i_clk);
            if (hold_out) begin
                hold_out = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(50, 400);
                end
                left--;
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= $urandom_range(0, 1);
                    2: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ($urandom_range(0, 15) == 0);
                endcase
            end
        end
    end

    // result checking, sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_alloc_address, o_status);
    end

    // watchdog: ends the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("FAIL buddy_page_allocator");
            $finish;
        end
    end

    task automatic write_base(input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.base = value;
    endtask

    task automatic wait_drained();
        while (sb.grant_q.size() != 0) @(posedge i_clk);
    endtask

    // Offer one transaction and hold it until accepted; then, when pace is set, apply the
    // sender's burst/gap pattern. Called at a rising edge.
    task automatic send_request(input t_action act, input logic [31:0] addr,
                                input logic [22:0] size, input logic [3:0] min_ord,
                                input bit pace);
        t_grant g;
        int     gap;
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_address    <= addr;
        i_size_bytes <= size;
        i_min_order  <= min_ord;
        do @(posedge i_clk); while (!o_in_ready);
        g = sb.note_request(act, addr, size, min_ord);
        if (act == ACT_ALLOC && g.status == STAT_DONE)
            live_q.push_back('{(g.alloc_address - sb.base) >> PAGE_SHIFT, size});
        gap = 0;
        if (pace) begin
            if (burst_left > 0) burst_left--;
            else begin
                burst_left = $urandom_range(1, 30);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic flush_sender();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One random transaction: mostly returns of live regions and small
    // allocates, with some noise frees and oversize or odd requests.
    task automatic random_request(input bit pace);
        int          pick, idx;
        t_region     r;
        logic [22:0] size;
        logic [3:0]  mo;
        pick = $urandom_range(0, 99);
        if (live_q.size() > 0 && (pick < 38 || live_q.size() > 150)) begin
            idx = $urandom_range(0, live_q.size() - 1);
            r   = live_q[idx];
            live_q.delete(idx);
            send_request(ACT_FREE, sb.base + (r.page << PAGE_SHIFT)
                         + $urandom_range(0, PAGE_BYTES - 1), 23'(r.bytes),
                         4'($urandom_range(0, 15)), pace);
        end else if (pick >= 90) begin
            send_request(ACT_FREE, $urandom, 23'($urandom_range(0, 4194304)),
                         4'($urandom_range(0, 15)), pace);
        end else begin
            case ($urandom_range(0, 9))
                0, 1:    size = 23'($urandom_range(1, 64 * PAGE_BYTES));
                2:       size = 23'($urandom_range(0, 4194304));
                default: size = 23'($urandom_range(1, 4 * PAGE_BYTES));
            endcase
            case ($urandom_range(0, 19))
                0:       mo = 4'($urandom_range(11, 15));
                1, 2, 3: mo = 4'($urandom_range(0, 10));
                default: mo = 4'($urandom_range(0, 3));
            endcase
            send_request(ACT_ALLOC, $urandom, size, mo, pace);
        end
    endtask

    initial begin
        logic [31:0] bases [4];
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        i_in_valid   = 1'b0;
        i_action     = ACT_ALLOC;
        i_address    = '0;
        i_size_bytes = '0;
        i_min_order  = '0;
        hold_out     = 1'b0;
        burst_left   = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: whole memory, exhaustion, zero sizes, odd frees
        write_base(32'h0000_0000);
        send_request(ACT_ALLOC, 32'hFFFF_FFFF, 23'd4194304, 4'd0, 0);
        send_request(ACT_ALLOC, 32'h0, 23'd1, 4'd0, 0);               // nothing left
        send_request(ACT_FREE,  32'h0, 23'd4194304, 4'd0, 0);         // merge back whole
        send_request(ACT_ALLOC, 32'h0, 23'd0, 4'd0, 0);               // zero size, one page
        send_request(ACT_ALLOC, 32'h0, 23'(3 * PAGE_BYTES), 4'd0, 0);
        send_request(ACT_ALLOC, 32'h0, 23'd5000, 4'd10, 0);
        send_request(ACT_ALLOC, 32'h0, 23'd1, 4'd15, 0);              // min order too high
        send_request(ACT_ALLOC, 32'h0, 23'd1, 4'd11, 0);
        send_request(ACT_FREE,  32'h0000_0FFF, 23'd1, 4'd0, 0);       // offset in page
        send_request(ACT_FREE,  32'h0000_1000, 23'd0, 4'd0, 0);       // frees nothing
        send_request(ACT_FREE,  32'h003F_F000, 23'(2 * PAGE_BYTES), 4'd0, 0); // runs past end
        send_request(ACT_FREE,  32'hFFFF_F000, 23'(PAGE_BYTES), 4'd0, 0);     // far outside
        send_request(ACT_FREE,  32'h0000_3000, 23'(2 * PAGE_BYTES), 4'd0, 0); // misaligned
        send_request(ACT_FREE,  32'h0000_3000, 23'(2 * PAGE_BYTES), 4'd0, 0); // double free
        send_request(ACT_ALLOC, 32'h0, 23'd4096, 4'd0, 0);
        send_request(ACT_ALLOC, 32'h0, 23'd4194303, 4'd0, 0);
        send_request(ACT_FREE,  32'hFFFF_FFFF, 23'd4194304, 4'd15, 0);
        send_request(ACT_ALLOC, 32'h0, 23'h2A_AAAA, 4'd5, 0);
        send_request(ACT_FREE,  32'h5555_5555, 23'h15_5555, 4'd10, 0);
        flush_sender();
        wait_drained();

        // random phases, each under a different base address
        bases[0] = 32'hFFC0_0000;
        bases[1] = 32'h1234_5000;
        bases[2] = {20'($urandom_range(0, 20'hFFBFF)), 12'h000};
        bases[3] = 32'h0000_0000;
        for (int ph = 0; ph < 4; ph++) begin
            write_base(bases[ph]);
            for (int n = 0; n < N_RANDOM / 4; n++)
                random_request(1);
            flush_sender();
            if (ph == 1) begin
                // receiver holds off while frees keep coming, so the input stalls
                hold_out = 1'b1;
                for (int n = 0; n < 20; n++)
                    send_request(ACT_FREE, $urandom, 23'($urandom_range(1, 8 * PAGE_BYTES)),
                                 4'd0, 0);
                flush_sender();
            end
            // sender pauses until every result is back
            wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.grant_q.size() == 0)
            $display("PASS buddy_page_allocator");
        else
            $display("FAIL buddy_page_allocator");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/bpa_pkg.sv
rtl/core/bpa_ram.sv
rtl/core/buddy_page_allocator.sv
test/testbench.sv
